/* rtl/plt_pkg.sv */
package plt_pkg;

  localparam int DEF_ENTRIES = 4;
  localparam int SLOT_W      = 4;
  localparam int COUNT_W     = 5;
  localparam int CODE_W      = 24;
  localparam int NUM_W       = 10;

  localparam logic [CODE_W-1:0] CLEAR_CODE = 24'hFFFFFF;
  localparam logic [3:0]        NIB_F      = 4'hF;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_REM_VAL = 3'd1,
    OP_REM_IDX = 3'd2,
    OP_FIND    = 3'd3,
    OP_LOAD    = 3'd4,
    OP_READ    = 3'd5
  } op_e_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  // mcc in the top bits, flag in bit 0
  typedef struct packed {
    logic [NUM_W-1:0] mcc;
    logic [NUM_W-1:0] mnc;
    logic             flag;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              exec;
    logic [2:0]        op;
    entry_t            val;
    entry_t            load_val;
    logic [SLOT_W-1:0] slot;
    logic              slot_ok;
  } cell_cmd_t;

  // leading decimal digits, stopping at the first nibble above 9
  function automatic logic [NUM_W-1:0] parse_digits(input logic [3:0] d0,
                                                    input logic [3:0] d1,
                                                    input logic [3:0] d2,
                                                    input logic three);
    logic [3:0]       d [3];
    logic [NUM_W-1:0] v;
    logic             stop;
    d[0] = d0;
    d[1] = d1;
    d[2] = d2;
    v    = '0;
    stop = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (!stop && (i < 2 || three)) begin
        if (d[i] > 4'd9) begin
          stop = 1'b1;
        end else begin
          v = (v * NUM_W'(10)) + NUM_W'(d[i]);
        end
      end
    end
    return v;
  endfunction

  function automatic entry_t from_code(input logic [CODE_W-1:0] code);
    logic [3:0] c [6];
    entry_t     e;
    logic       two;
    for (int i = 0; i < 6; i++) begin
      c[i] = code[23 - 4*i -: 4];
    end
    two    = (c[2] == NIB_F);
    e.mcc  = parse_digits(c[1], c[0], c[3], 1'b1);
    e.mnc  = parse_digits(c[5], c[4], c[2], !two);
    e.flag = two;
    if (code == CLEAR_CODE) begin
      e = '0;
    end
    return e;
  endfunction

  // hundreds (mod 10), tens and ones of a 10-bit value
  function automatic logic [11:0] to_bcd3(input logic [NUM_W-1:0] v);
    logic [15:0] p;
    logic [3:0]  q;
    logic [10:0] r;
    logic [14:0] pt;
    logic [3:0]  t;
    logic [6:0]  o;
    logic [3:0]  h;
    p = 16'(v) * 16'd41;
    q = p[15:12];
    r = 11'(v) - (11'(q) * 11'd100);
    if (r >= 11'd100) begin
      q = q + 4'd1;
      r = r - 11'd100;
    end
    h  = (q >= 4'd10) ? q - 4'd10 : q;
    pt = 15'(r[6:0]) * 15'd205;
    t  = pt[14:11];
    o  = r[6:0] - (7'(t) * 7'd10);
    if (o >= 7'd10) begin
      t = t + 4'd1;
      o = o - 7'd10;
    end
    return {h, t, o[3:0]};
  endfunction

  function automatic logic [CODE_W-1:0] to_code(input entry_t e);
    logic [11:0] a;
    logic [11:0] b;
    logic [3:0]  s3;
    logic [3:0]  s4;
    logic [3:0]  s5;
    a = to_bcd3(e.mcc);
    b = to_bcd3(e.mnc);
    if (e.flag) begin
      s3 = b[7:4];
      s4 = b[3:0];
      s5 = NIB_F;
    end else begin
      s3 = b[11:8];
      s4 = b[7:4];
      s5 = b[3:0];
    end
    if (e.mcc == '0 && e.mnc == '0) begin
      return CLEAR_CODE;
    end
    return {a[7:4], a[11:8], s5, a[3:0], s4, s3};
  endfunction

endpackage

/* rtl/plmn_list_table_core.sv */
// Channel | Port group         | Transfer carries
// --------+--------------------+----------------------------------------------
// input   | in_tvalid/tready   | one list operation (op, value, slot, code)
// result  | out_tvalid/tready  | one result per operation (ok, slot, count,
//         |                    | code)
//
// Each operation passes through the execute state, in which every cell of the
// slot chain compares, shifts or writes its entry, and the done state, which
// forms the code and the entry count into the output register. A new operation
// is taken in the done state of the previous one when the output register is
// free. Reset clears all slots at once. A stalled result holds the block in its
// done state; no operation is taken until the result can be stored.
module plmn_list_table_core #(
  parameter int ENTRIES = plt_pkg::DEF_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // mcc[9:0], mnc[19:10], slot[23:20], code_in[47:24]
  input  logic [3:0]  in_tuser,   // op[2:0], two_digit_mnc[3]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // found_slot[3:0], entry_count[8:4], code_out[32:9]
  output logic [0:0]  out_tuser   // ok[0]
);
  import plt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  state_t state_r, state_nxt;

  logic [2:0]        op_r;
  entry_t            val_r;
  logic [SLOT_W-1:0] slot_r;
  logic [CODE_W-1:0] code_in_r;

  logic              ok_r, ok_nxt;
  logic [SLOT_W-1:0] found_r, found_nxt;
  entry_t            rd_r, rd_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r;
  logic [SLOT_W-1:0] out_found_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [CODE_W-1:0] out_code_r;

  logic              in_acc;
  logic              out_load;
  logic              slot_ok;
  cell_cmd_t         cmd;

  entry_t            entry_w [ENTRIES];
  logic [ENTRIES-1:0] hit_w;
  logic [ENTRIES-1:0] clr_w;
  logic [ENTRIES:0]  match_chain;
  logic [ENTRIES:0]  clear_chain;

  logic [COUNT_W-1:0] count;
  logic [CODE_W-1:0]  code_res;

  assign slot_ok = ({1'b0, slot_r} < (SLOT_W + 1)'(ENTRIES));

  always_comb begin
    cmd.exec     = (state_r == ST_EXEC);
    cmd.op       = op_r;
    cmd.val      = val_r;
    cmd.load_val = from_code(code_in_r);
    cmd.slot     = slot_r;
    cmd.slot_ok  = slot_ok;
  end

  assign match_chain[0] = 1'b0;
  assign clear_chain[0] = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t next_e;
    if (i == ENTRIES - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = entry_w[i+1];
    end

    plt_cell #(
      .IDX (i)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd          (cmd),
      .next_entry   (next_e),
      .match_before (match_chain[i]),
      .clear_before (clear_chain[i]),
      .any_match    (match_chain[ENTRIES]),
      .entry        (entry_w[i]),
      .hit          (hit_w[i]),
      .clr          (clr_w[i])
    );

    assign match_chain[i+1] = match_chain[i] | hit_w[i];
    assign clear_chain[i+1] = clear_chain[i] | clr_w[i];
  end

  // result flags and read data, sampled in the cell update cycle
  always_comb begin
    ok_nxt    = 1'b0;
    found_nxt = '0;
    rd_nxt    = '0;
    if (slot_ok) rd_nxt = entry_w[slot_r[IDX_W-1:0]];
    case (op_r)
      OP_ADD:     ok_nxt = match_chain[ENTRIES] | clear_chain[ENTRIES];
      OP_REM_VAL: ok_nxt = match_chain[ENTRIES];
      OP_REM_IDX: ok_nxt = slot_ok;
      OP_FIND: begin
        ok_nxt = match_chain[ENTRIES];
        for (int i = 0; i < ENTRIES; i++) begin
          if (hit_w[i] && !match_chain[i]) found_nxt = SLOT_W'(i);
        end
      end
      OP_LOAD:    ok_nxt = slot_ok;
      OP_READ:    ok_nxt = slot_ok;
      default:    ok_nxt = 1'b0;
    endcase
  end

  always_comb begin
    count = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      count = count + COUNT_W'(!clr_w[i]);
    end
  end

  always_comb begin
    code_res = '0;
    if (op_r == OP_READ) code_res = ok_r ? to_code(rd_r) : CLEAR_CODE;
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          in_tready = 1'b1;
          state_nxt = in_tvalid ? ST_EXEC : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_acc        = in_tvalid && in_tready;
  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r       <= in_tuser[2:0];
      val_r.mcc  <= in_tdata[9:0];
      val_r.mnc  <= in_tdata[19:10];
      val_r.flag <= in_tuser[3];
      slot_r     <= in_tdata[23:20];
      code_in_r  <= in_tdata[47:24];
    end
    if (state_r == ST_EXEC) begin
      ok_r    <= ok_nxt;
      found_r <= found_nxt;
      rd_r    <= rd_nxt;
    end
    if (out_load) begin
      out_ok_r    <= ok_r;
      out_found_r <= found_r;
      out_count_r <= count;
      out_code_r  <= code_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_code_r, out_count_r, out_found_r};
  assign out_tuser  = out_ok_r;

endmodule

/* rtl/plt_cell.sv */
module plt_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  plt_pkg::cell_cmd_t cmd,
  input  plt_pkg::entry_t    next_entry,
  input  logic               match_before,
  input  logic               clear_before,
  input  logic               any_match,
  output plt_pkg::entry_t    entry,
  output logic               hit,
  output logic               clr
);
  import plt_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  assign entry = entry_r;
  assign hit   = (entry_r == cmd.val);
  assign clr   = (entry_r.mcc == '0) && (entry_r.mnc == '0);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.exec) begin
      unique case (cmd.op)
        OP_ADD: begin
          // fill only the first clear slot, and only when the value is absent
          if (!any_match && clr && !clear_before) entry_nxt = cmd.val;
        end
        OP_REM_VAL: begin
          if (match_before || hit) entry_nxt = next_entry;
        end
        OP_REM_IDX: begin
          if (cmd.slot_ok && cmd.slot <= SLOT_W'(IDX)) entry_nxt = next_entry;
        end
        OP_LOAD: begin
          if (cmd.slot_ok && cmd.slot == SLOT_W'(IDX)) entry_nxt = cmd.load_val;
        end
        default: begin
          entry_nxt = entry_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

endmodule
